// ===== rtl/aesr_pkg.sv =====
// ----------------------------------------------------------------------------
// aesr_pkg
// Types, op codes and GF(2^8) helpers for the AES round unit.
// ----------------------------------------------------------------------------
package aesr_pkg;

  typedef enum logic [2:0] {
    OP_ENC_ROUND = 3'd0,
    OP_ENC_FINAL = 3'd1,
    OP_DEC_ROUND = 3'd2,
    OP_DEC_FINAL = 3'd3,
    OP_SUBWORD   = 3'd4,
    OP_INV_SUB   = 3'd5
  } aesr_op_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] state_hi;
    logic [63:0] state_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } aesr_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aesr_out_t;

  localparam logic [7:0] NIB_MASK = 8'h0F;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    gf_mul = r;
  endfunction

  // x^254; maps zero to zero
  function automatic logic [7:0] gf_inv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    for (int i = 0; i < 7; i++) begin
      p = gf_mul(p, p);
      r = gf_mul(r, p);
    end
    gf_inv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    rotl8 = (b << n) | (b >> (8 - n));
  endfunction

  function automatic logic [7:0] sbox_fwd(input logic [7:0] b);
    logic [7:0] v;
    v = gf_inv(b);
    sbox_fwd = v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] sbox_inv(input logic [7:0] s);
    sbox_inv = gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  // Constant S-box tables, built at elaboration.
  function automatic logic [255:0][7:0] mk_fwd();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) t[i] = sbox_fwd(8'(i));
    mk_fwd = t;
  endfunction

  function automatic logic [255:0][7:0] mk_inv();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) t[i] = sbox_inv(8'(i));
    mk_inv = t;
  endfunction

  localparam logic [255:0][7:0] SBOX_FWD = mk_fwd();
  localparam logic [255:0][7:0] SBOX_INV = mk_inv();

endpackage

// ===== rtl/aesr_core.sv =====
// ----------------------------------------------------------------------------
// aesr_core
// Combinational datapath of one AES round or word substitution.
// ----------------------------------------------------------------------------
module aesr_core (
  input  aesr_pkg::aesr_in_t  in_i,
  output aesr_pkg::aesr_out_t out_o
);
  import aesr_pkg::*;

  logic [15:0][7:0] s, k, sr_f, sb_f, mc_f, sr_i, sb_i, ak_i, mc_i, res;
  logic [15:0][7:0] ak_f;
  logic [31:0] word_f, word_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      s[i]     = in_i.state_hi[63-8*i -: 8];
      s[8+i]   = in_i.state_lo[63-8*i -: 8];
      k[i]     = in_i.key_hi[63-8*i -: 8];
      k[8+i]   = in_i.key_lo[63-8*i -: 8];
    end
    // encrypt path
    for (int i = 0; i < 16; i++) sb_f[i] = SBOX_FWD[s[i]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        sr_f[4*c+r] = sb_f[4*((c+r)&3)+r];
        sr_i[4*c+r] = s[4*((c-r+4)&3)+r];
      end
    for (int c = 0; c < 4; c++) begin
      mc_f[4*c+0] = xtime(sr_f[4*c]) ^ xtime(sr_f[4*c+1]) ^ sr_f[4*c+1]
                    ^ sr_f[4*c+2] ^ sr_f[4*c+3];
      mc_f[4*c+1] = sr_f[4*c] ^ xtime(sr_f[4*c+1]) ^ xtime(sr_f[4*c+2])
                    ^ sr_f[4*c+2] ^ sr_f[4*c+3];
      mc_f[4*c+2] = sr_f[4*c] ^ sr_f[4*c+1] ^ xtime(sr_f[4*c+2])
                    ^ xtime(sr_f[4*c+3]) ^ sr_f[4*c+3];
      mc_f[4*c+3] = xtime(sr_f[4*c]) ^ sr_f[4*c] ^ sr_f[4*c+1]
                    ^ sr_f[4*c+2] ^ xtime(sr_f[4*c+3]);
    end
    for (int i = 0; i < 16; i++) begin
      ak_f[i] = ((in_i.op == OP_ENC_ROUND) ? mc_f[i] : sr_f[i]) ^ k[i];
      sb_i[i] = SBOX_INV[sr_i[i]];
      ak_i[i] = sb_i[i] ^ k[i];
    end
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        mc_i[4*c+r] = gf_mul(8'd14, ak_i[4*c+r]) ^ gf_mul(8'd11, ak_i[4*c+((r+1)&3)])
                    ^ gf_mul(8'd13, ak_i[4*c+((r+2)&3)]) ^ gf_mul(8'd9, ak_i[4*c+((r+3)&3)]);
    for (int i = 0; i < 4; i++) begin
      word_f[8*i +: 8] = SBOX_FWD[in_i.state_lo[8*i +: 8]];
      word_i[8*i +: 8] = SBOX_INV[in_i.state_lo[8*i +: 8]];
    end
    res = '0;
    out_o = '0;
    case (in_i.op)
      OP_ENC_ROUND, OP_ENC_FINAL: res = ak_f;
      OP_DEC_ROUND: res = mc_i;
      OP_DEC_FINAL: res = ak_i;
      default: res = '0;
    endcase
    for (int i = 0; i < 8; i++) begin
      out_o.result_hi[63-8*i -: 8] = res[i];
      out_o.result_lo[63-8*i -: 8] = res[8+i];
    end
    if (in_i.op == OP_SUBWORD) out_o.result_lo = {32'h0, word_f};
    else if (in_i.op == OP_INV_SUB) out_o.result_lo = {32'h0, word_i};
  end

endmodule

// ===== rtl/aes_round_unit.sv =====
// ----------------------------------------------------------------------------
// aes_round_unit
// One AES-128 round or S-box word substitution per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries op, state and round key.
//   Output channel out_valid_o/out_ready_i carries the new state, or the
//   substituted word in result_lo[31:0] for word ops.
//   The input is registered, the round logic sits between that register
//   and the result register: an item passes the input register and then
//   the result register before its result is offered on the output.
//   Throughput is one item per cycle while the receiver takes every result, set by the single-pass round logic.
//   A stalled receiver holds the result; the input register still takes
//   one more item while the result waits, then ready drops.
//   Reset clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module aes_round_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aesr_pkg::aesr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aesr_pkg::aesr_out_t out_data_o
);
  import aesr_pkg::*;

  aesr_in_t  in_q;
  logic      in_vld_q, out_vld_q;
  aesr_out_t out_q, core_res;
  logic      out_load, in_load;

  aesr_core u_core (.in_i(in_q), .out_o(core_res));

  assign out_load   = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || out_load;
  assign in_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) in_q <= in_data_i;
    if (out_load) out_q <= core_res;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== test/tb_aes_round_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aes_round_unit
// Self-checking bench for the AES round unit: a directed table of rounds,
// word substitutions and unused op codes, then random transfers under
// varying source and sink idling, checked against typed results or a round model.
// ----------------------------------------------------------------------------
module tb_aes_round_unit;
  import aesr_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  aesr_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  aesr_out_t out_data_o;

  aes_round_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aesr_out_t round_q[$];
  int        errors = 0;
  int        n_sent = 0;
  int        n_recv = 0;
  int        src_idle = 37;
  int        snk_idle = 65;
  int        op_count[8];

  // ---- round model ----
  function automatic logic [7:0] mul_gf(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] inv_gf(logic [7:0] x);
    logic [7:0] r;
    r = 8'h01;
    for (int i = 0; i < 254; i++) r = mul_gf(r, x);
    return r;
  endfunction

  function automatic logic [7:0] rot8(logic [7:0] b, int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  logic [7:0] fwd_tab[256];
  logic [7:0] inv_tab[256];

  initial begin
    logic [7:0] v;
    for (int i = 0; i < 256; i++) begin
      v = inv_gf(8'(i));
      fwd_tab[i] = v ^ rot8(v, 1) ^ rot8(v, 2) ^ rot8(v, 3) ^ rot8(v, 4) ^ 8'h63;
      v = 8'(i);
      inv_tab[i] = inv_gf(rot8(v, 1) ^ rot8(v, 3) ^ rot8(v, 6) ^ 8'h05);
    end
  end

  function automatic aesr_out_t aes_round(aesr_in_t it);
    logic [7:0] s[16], k[16], t[16];
    logic [7:0] mf[4], mi[4], acc;
    logic [127:0] sv, kv, rv;
    aesr_out_t res;
    mf = '{8'd2, 8'd3, 8'd1, 8'd1};
    mi = '{8'd14, 8'd11, 8'd13, 8'd9};
    res = '0;
    sv = {it.state_hi, it.state_lo};
    kv = {it.key_hi, it.key_lo};
    for (int i = 0; i < 16; i++) begin
      s[i] = sv[127-8*i -: 8];
      k[i] = kv[127-8*i -: 8];
    end
    case (it.op)
      OP_ENC_ROUND, OP_ENC_FINAL, OP_DEC_ROUND, OP_DEC_FINAL: begin
        if (it.op inside {OP_ENC_ROUND, OP_ENC_FINAL}) begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[4*c+r] = fwd_tab[s[4*((c+r)&3)+r]];
          if (it.op == OP_ENC_ROUND)
            for (int c = 0; c < 4; c++)
              for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) acc ^= mul_gf(mf[(j-r+4)&3], t[4*c+j]);
                s[4*c+r] = acc;
              end
          else s = t;
          for (int i = 0; i < 16; i++) s[i] ^= k[i];
        end else begin
          for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
              t[4*c+r] = inv_tab[s[4*((c-r+4)&3)+r]] ^ k[4*c+r];
          if (it.op == OP_DEC_ROUND)
            for (int c = 0; c < 4; c++)
              for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int j = 0; j < 4; j++) acc ^= mul_gf(mi[(j-r+4)&3], t[4*c+j]);
                s[4*c+r] = acc;
              end
          else s = t;
        end
        for (int i = 0; i < 16; i++) rv[127-8*i -: 8] = s[i];
        res = rv;
      end
      OP_SUBWORD:
        for (int i = 0; i < 4; i++)
          res.result_lo[8*i +: 8] = fwd_tab[it.state_lo[8*i +: 8]];
      OP_INV_SUB:
        for (int i = 0; i < 4; i++)
          res.result_lo[8*i +: 8] = inv_tab[it.state_lo[8*i +: 8]];
      default: res = '0;
    endcase
    return res;
  endfunction

  // ---- directed table; exp_ok marks rows whose result is typed in ----
  typedef struct {
    aesr_in_t  item;
    bit        exp_ok;
    aesr_out_t exp;
  } vec_t;

  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  vec_t vec_tab[] = '{
    '{'{OP_SUBWORD, 64'h0, 64'h0, 64'h0, 64'h0}, 1, '{64'h0, 64'h0000_0000_6363_6363}},
    '{'{OP_SUBWORD, ONES, ONES, ONES, ONES}, 1, '{64'h0, 64'h0000_0000_1616_1616}},
    '{'{OP_INV_SUB, ONES, 64'h0, ONES, ONES}, 1, '{64'h0, 64'h0000_0000_5252_5252}},
    '{'{OP_INV_SUB, 64'h0, 64'h0000_0000_6363_6363, 64'h0, 64'h0}, 1, '{64'h0, 64'h0}},
    '{'{3'd6, ONES, ONES, ONES, ONES}, 1, '{64'h0, 64'h0}},
    '{'{3'd7, ONES, ONES, ONES, ONES}, 1, '{64'h0, 64'h0}},
    '{'{OP_ENC_FINAL, 64'h0, 64'h0, 64'h0, 64'h0}, 1,
      '{64'h6363_6363_6363_6363, 64'h6363_6363_6363_6363}},
    '{'{OP_ENC_ROUND, 64'h0, 64'h0, 64'h0, 64'h0}, 1,
      '{64'h6363_6363_6363_6363, 64'h6363_6363_6363_6363}},
    '{'{OP_ENC_ROUND, ONES, ONES, ONES, ONES}, 0, '{64'h0, 64'h0}},
    '{'{OP_ENC_FINAL, ONES, ONES, 64'h0, 64'h0}, 0, '{64'h0, 64'h0}},
    '{'{OP_DEC_ROUND, 64'h0, 64'h0, 64'h0, 64'h0}, 0, '{64'h0, 64'h0}},
    '{'{OP_DEC_ROUND, ONES, ONES, ONES, ONES}, 0, '{64'h0, 64'h0}},
    '{'{OP_DEC_FINAL, 64'h0, 64'h0, 64'h0, 64'h0}, 1,
      '{64'h5252_5252_5252_5252, 64'h5252_5252_5252_5252}},
    '{'{OP_DEC_FINAL, ONES, ONES, ONES, ONES}, 0, '{64'h0, 64'h0}},
    // FIPS-197 round 1 state with the round-1 key
    '{'{OP_ENC_ROUND, 64'h193d_e3be_a0f4_e22b, 64'h9ac6_8d2a_e9f8_4808,
        64'ha0fa_fe17_8854_2cb1, 64'h23a3_3939_2a6c_7605}, 1,
      '{64'ha49c_7ff2_689f_352b, 64'h6b5b_ea43_026a_5049}},
    '{'{OP_ENC_FINAL, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
        64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001}, 0, '{64'h0, 64'h0}},
    '{'{OP_DEC_ROUND, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
        64'h0f0f_0f0f_f0f0_f0f0, 64'h5555_aaaa_5555_aaaa}, 0, '{64'h0, 64'h0}},
    '{'{OP_SUBWORD, ONES, 64'hdead_beef_0001_80ff, ONES, 64'h0}, 0, '{64'h0, 64'h0}}
  };

  task automatic send_item(aesr_in_t it, aesr_out_t exp);
    while ($urandom_range(99) < src_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    op_count[it.op]++;
    do @(posedge clk_i); while (!in_ready_o);
    round_q.push_back(exp);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic aesr_in_t rand_item();
    aesr_in_t it;
    it.op = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    it.state_hi = {$urandom, $urandom};
    it.state_lo = {$urandom, $urandom};
    it.key_hi   = {$urandom, $urandom};
    it.key_lo   = {$urandom, $urandom};
    return it;
  endfunction

  initial begin
    aesr_in_t it;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // typed rows are checked against their typed result, the rest against the model
    foreach (vec_tab[i]) begin
      if (vec_tab[i].exp_ok)
        send_item(vec_tab[i].item, vec_tab[i].exp);
      else
        send_item(vec_tab[i].item, aes_round(vec_tab[i].item));
    end
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 37 : (ph == 1) ? 65 : 0;
      snk_idle = (ph == 0) ? 65 : (ph == 1) ? 37 : 0;
      for (int i = 0; i < 450; i++) begin
        it = rand_item();
        send_item(it, aes_round(it));
      end
    end
    in_valid_i <= 1'b0;
    while (round_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d transfers, checked %0d results; ops 0-7: %0d %0d %0d %0d %0d %0d %0d %0d",
             n_sent, n_recv, op_count[0], op_count[1], op_count[2], op_count[3],
             op_count[4], op_count[5], op_count[6], op_count[7]);
    if (errors == 0 && round_q.size() == 0)
      $display("tb_aes_round_unit: PASS");
    else
      $display("tb_aes_round_unit: FAIL");
    $finish;
  end

  // sink: random back-pressure, check on every output transfer
  always @(negedge clk_i)
    out_ready_i <= rst_ni && ($urandom_range(99) >= snk_idle);

  always @(posedge clk_i) begin
    aesr_out_t exp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_recv++;
      if (round_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, out_data_o);
      end else begin
        exp = round_q.pop_front();
        if (exp.result_hi !== out_data_o.result_hi) begin
          errors++;
          $display("%0t result_hi expected %h got %h", $time, exp.result_hi,
                   out_data_o.result_hi);
        end
        if (exp.result_lo !== out_data_o.result_lo) begin
          errors++;
          $display("%0t result_lo expected %h got %h", $time, exp.result_lo,
                   out_data_o.result_lo);
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("tb_aes_round_unit: FAIL");
    $finish;
  end

endmodule
